### rtl/core/ctp_pkg.sv
// Shared types and constants for the chat markup tag parser.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package ctp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LEFT_SEP    = 3'd0,
    CFG_RIGHT_SEP   = 3'd1,
    CFG_PARAM_SEP   = 3'd2,
    CFG_CONTENT_SEP = 3'd3,
    CFG_TAGS_W0     = 3'd4,
    CFG_TAGS_W1     = 3'd5,
    CFG_TAGS_W2     = 3'd6,
    CFG_TAGS_W3     = 3'd7
  } ctp_cfg_idx_e;

  // Reset values of the separator registers
  localparam logic [7:0] LEFT_SEP_RST    = 8'd91;
  localparam logic [7:0] RIGHT_SEP_RST   = 8'd93;
  localparam logic [7:0] PARAM_SEP_RST   = 8'd32;
  localparam logic [7:0] CONTENT_SEP_RST = 8'd58;

  // Byte roles reported with each result
  typedef enum logic [3:0] {
    ROLE_TEXT     = 4'd0,
    ROLE_OPEN     = 4'd1,
    ROLE_TYPE     = 4'd2,
    ROLE_PSEP     = 4'd3,
    ROLE_PARAM    = 4'd4,
    ROLE_CSEP     = 4'd5,
    ROLE_CONTENT  = 4'd6,
    ROLE_CLOSE    = 4'd7,
    ROLE_FALLBACK = 4'd8,
    ROLE_IGNORED  = 4'd9,
    ROLE_END      = 4'd10
  } ctp_role_e;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_TEXT     = 3'd1,
    PH_TYPE     = 3'd2,
    PH_PARAMS   = 3'd3,
    PH_CONTENT  = 3'd4,
    PH_FALLBACK = 3'd5,
    PH_IGNORE   = 3'd6
  } ctp_phase_e;

  // Depth of the queue between classifier and parser
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified byte, handed from front to back
  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_zero;
    logic       is_left;
    logic       is_right;
    logic       is_psep;
    logic       is_csep;
    logic       type_ok;
  } ctp_byte_t;

  // One result item
  typedef struct packed {
    logic [7:0] byte_value;
    ctp_role_e  role;
    logic [4:0] segment_index;
    logic [7:0] tag_type;
    logic [2:0] param_index;
    logic       rollback;
    logic       parse_ok;
  } ctp_result_t;

endpackage

`default_nettype wire

### rtl/core/ctp_front.sv
// Front end: configuration registers and per-byte classification.
// Depends on ctp_pkg.
`default_nettype none

module ctp_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [63:0]         cfg_data_i,
  input  wire logic [7:0]          char_byte_i,
  output ctp_pkg::ctp_byte_t       cls_o
);

  logic [7:0]       left_q, right_q, psep_q, csep_q;
  logic [3:0][63:0] tags_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= ctp_pkg::LEFT_SEP_RST;
      right_q <= ctp_pkg::RIGHT_SEP_RST;
      psep_q  <= ctp_pkg::PARAM_SEP_RST;
      csep_q  <= ctp_pkg::CONTENT_SEP_RST;
      tags_q  <= '0;
    end else if (cfg_we_i) begin
      case (ctp_pkg::ctp_cfg_idx_e'(cfg_idx_i))
        ctp_pkg::CFG_LEFT_SEP:    left_q    <= cfg_data_i[7:0];
        ctp_pkg::CFG_RIGHT_SEP:   right_q   <= cfg_data_i[7:0];
        ctp_pkg::CFG_PARAM_SEP:   psep_q    <= cfg_data_i[7:0];
        ctp_pkg::CFG_CONTENT_SEP: csep_q    <= cfg_data_i[7:0];
        ctp_pkg::CFG_TAGS_W0:     tags_q[0] <= cfg_data_i;
        ctp_pkg::CFG_TAGS_W1:     tags_q[1] <= cfg_data_i;
        ctp_pkg::CFG_TAGS_W2:     tags_q[2] <= cfg_data_i;
        ctp_pkg::CFG_TAGS_W3:     tags_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte compares and valid-type lookup
  always_comb begin
    cls_o.char_byte = char_byte_i;
    cls_o.is_zero   = (char_byte_i == 8'd0);
    cls_o.is_left   = (char_byte_i == left_q);
    cls_o.is_right  = (char_byte_i == right_q);
    cls_o.is_psep   = (char_byte_i == psep_q);
    cls_o.is_csep   = (char_byte_i == csep_q);
    cls_o.type_ok   = tags_q[char_byte_i[7:6]][char_byte_i[5:0]];
  end

endmodule

`default_nettype wire

### rtl/core/ctp_queue.sv
// Short queue of classified bytes between front and back.
// Depends on ctp_pkg.
`default_nettype none

module ctp_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ctp_pkg::ctp_byte_t  data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output ctp_pkg::ctp_byte_t       data_o
);

  localparam int unsigned Depth = ctp_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ctp_pkg::ctp_byte_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ctp_back.sv
// Back end: parser state machine and registered result stage.
// Depends on ctp_pkg.
`default_nettype none

module ctp_back #(
  parameter int unsigned MAX_TAGS      = 16,
  parameter int unsigned MAX_PARAMS    = 4,
  parameter int unsigned MAX_PARAM_LEN = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire ctp_pkg::ctp_byte_t  q_data_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ctp_pkg::ctp_result_t     res_o
);

  localparam int unsigned SegW  = $clog2(MAX_TAGS + 1);
  localparam int unsigned PCntW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned PLenW = $clog2(MAX_PARAM_LEN);
  localparam logic [SegW-1:0]  SegMax  = SegW'(MAX_TAGS);
  localparam logic [PCntW-1:0] PCntMax = PCntW'(MAX_PARAMS);
  localparam logic [PLenW-1:0] PLenLim = PLenW'(MAX_PARAM_LEN - 1);

  ctp_pkg::ctp_phase_e  phase_q, phase_d;
  logic [SegW-1:0]      seg_q, seg_d;
  logic [7:0]           type_q, type_d;
  logic [PCntW-1:0]     pcnt_q, pcnt_d;
  logic [PLenW-1:0]     plen_q, plen_d;
  logic                 limit_q, limit_d;

  logic                 out_valid_q, out_valid_d;
  ctp_pkg::ctp_result_t res_q, res_d;

  ctp_pkg::ctp_byte_t   c;
  logic                 pop;
  logic                 start_w, full_w, fail_w;
  logic [SegW-1:0]      seg_w;
  logic [PCntW-1:0]     pidx_w;
  logic [SegW+4:0]      seg_ext;
  logic [PCntW+2:0]     pidx_ext;

  assign c       = q_data_i;
  assign pop     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  // Decode: segment start, segment limit and tag failure
  always_comb begin
    start_w = !c.is_zero &&
              ((phase_q == ctp_pkg::PH_IDLE) || ((phase_q == ctp_pkg::PH_TEXT) && c.is_left));
    full_w  = (seg_q == SegMax);
    fail_w  = 1'b0;
    if (!c.is_zero && !start_w) begin
      case (phase_q)
        ctp_pkg::PH_TYPE: fail_w = !c.type_ok;
        ctp_pkg::PH_PARAMS: begin
          if (!c.is_psep && !c.is_csep && !c.is_right) begin
            fail_w = (plen_q != '0) ? (plen_q == PLenLim) : (pcnt_q == PCntMax);
          end
        end
        default: fail_w = 1'b0;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    seg_d   = seg_q;
    type_d  = type_q;
    pcnt_d  = pcnt_q;
    plen_d  = plen_q;
    limit_d = limit_q;
    if (c.is_zero) begin
      phase_d = ctp_pkg::PH_IDLE;
      seg_d   = '0;
      type_d  = '0;
      pcnt_d  = '0;
      plen_d  = '0;
      limit_d = 1'b0;
    end else if (start_w) begin
      if (full_w) begin
        limit_d = 1'b1;
        phase_d = ctp_pkg::PH_IGNORE;
      end else begin
        seg_d   = seg_q + 1'b1;
        phase_d = c.is_left ? ctp_pkg::PH_TYPE : ctp_pkg::PH_TEXT;
      end
    end else if (fail_w) begin
      type_d  = '0;
      pcnt_d  = '0;
      plen_d  = '0;
      phase_d = ctp_pkg::PH_FALLBACK;
    end else begin
      case (phase_q)
        ctp_pkg::PH_TYPE: begin
          type_d  = c.char_byte;
          pcnt_d  = '0;
          plen_d  = '0;
          phase_d = ctp_pkg::PH_PARAMS;
        end
        ctp_pkg::PH_PARAMS: begin
          if (c.is_psep) begin
            plen_d = '0;
          end else if (c.is_csep) begin
            phase_d = ctp_pkg::PH_CONTENT;
          end else if (c.is_right) begin
            phase_d = ctp_pkg::PH_IDLE;
          end else if (plen_q != '0) begin
            plen_d = plen_q + 1'b1;
          end else begin
            pcnt_d = pcnt_q + 1'b1;
            plen_d = PLenW'(1);
          end
        end
        ctp_pkg::PH_CONTENT: begin
          if (c.is_right) begin
            phase_d = ctp_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields
  always_comb begin
    res_d            = '0;
    res_d.byte_value = c.char_byte;
    res_d.role       = ctp_pkg::ROLE_TEXT;
    seg_w            = seg_q - 1'b1;
    pidx_w           = '0;
    if (c.is_zero) begin
      res_d.role     = ctp_pkg::ROLE_END;
      seg_w          = seg_q;
      res_d.rollback = (phase_q == ctp_pkg::PH_TYPE) || (phase_q == ctp_pkg::PH_PARAMS) ||
                       (phase_q == ctp_pkg::PH_CONTENT);
      res_d.parse_ok = !limit_q && !full_w;
    end else if (start_w) begin
      seg_w = seg_q;
      if (full_w) begin
        res_d.role = ctp_pkg::ROLE_IGNORED;
      end else begin
        res_d.role = c.is_left ? ctp_pkg::ROLE_OPEN : ctp_pkg::ROLE_TEXT;
      end
    end else if (fail_w) begin
      res_d.role     = ctp_pkg::ROLE_FALLBACK;
      res_d.rollback = 1'b1;
    end else begin
      case (phase_q)
        ctp_pkg::PH_TEXT: res_d.role = ctp_pkg::ROLE_TEXT;
        ctp_pkg::PH_TYPE: begin
          res_d.role     = ctp_pkg::ROLE_TYPE;
          res_d.tag_type = c.char_byte;
        end
        ctp_pkg::PH_PARAMS: begin
          res_d.tag_type = type_q;
          if (c.is_psep) begin
            res_d.role = ctp_pkg::ROLE_PSEP;
          end else if (c.is_csep) begin
            res_d.role = ctp_pkg::ROLE_CSEP;
          end else if (c.is_right) begin
            res_d.role = ctp_pkg::ROLE_CLOSE;
          end else begin
            res_d.role = ctp_pkg::ROLE_PARAM;
            // continuing bytes use the last count, a new parameter the old count
            pidx_w     = (plen_q != '0) ? pcnt_q - 1'b1 : pcnt_q;
          end
        end
        ctp_pkg::PH_CONTENT: begin
          res_d.tag_type = type_q;
          res_d.role     = c.is_right ? ctp_pkg::ROLE_CLOSE : ctp_pkg::ROLE_CONTENT;
        end
        ctp_pkg::PH_FALLBACK: res_d.role = ctp_pkg::ROLE_FALLBACK;
        default: begin
          res_d.role = ctp_pkg::ROLE_IGNORED;
          seg_w      = seg_q;
        end
      endcase
    end
    seg_ext             = {5'b0, seg_w};
    pidx_ext            = {3'b0, pidx_w};
    res_d.segment_index = seg_ext[4:0];
    res_d.param_index   = pidx_ext[2:0];
  end

  // Output stage handshake
  always_comb begin
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ctp_pkg::PH_IDLE;
      seg_q       <= '0;
      type_q      <= '0;
      pcnt_q      <= '0;
      plen_q      <= '0;
      limit_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        phase_q <= phase_d;
        seg_q   <= seg_d;
        type_q  <= type_d;
        pcnt_q  <= pcnt_d;
        plen_q  <= plen_d;
        limit_q <= limit_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_seg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q <= SegMax)
    else $error("segment count above limit");

  a_limit_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q |-> (phase_q == ctp_pkg::PH_IGNORE))
    else $error("limit hit outside ignore phase");

  a_rollback_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.rollback) |->
      (res_q.role == ctp_pkg::ROLE_FALLBACK || res_q.role == ctp_pkg::ROLE_END))
    else $error("rollback on a non-fallback byte");

  a_ok_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.parse_ok) |-> (res_q.role == ctp_pkg::ROLE_END))
    else $error("parse_ok away from end byte");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_q)
    else $error("popped byte produced no result");
`endif

endmodule

`default_nettype wire

### rtl/core/chat_markup_tag_parser.sv
// Chat markup tag parser, one message byte per request, one result per byte.
// An accepted byte passes through the queue and then the registered result stage.
// Throughput: one byte per cycle while the output is not stalled.
// A stalled output fills the two-entry queue, after which input stalls.
// Reset clears parse state and queue and loads default separators; no sweep.
// Depends on ctp_pkg, ctp_front, ctp_queue, ctp_back.
`default_nettype none

module chat_markup_tag_parser #(
  parameter int unsigned MAX_TAGS      = 16,
  parameter int unsigned MAX_PARAMS    = 4,
  parameter int unsigned MAX_PARAM_LEN = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       byte_value_o,
  output logic [3:0]       role_o,
  output logic [4:0]       segment_index_o,
  output logic [7:0]       tag_type_o,
  output logic [2:0]       param_index_o,
  output logic             rollback_o,
  output logic             parse_ok_o
);

  ctp_pkg::ctp_byte_t   cls_w, q_data_w;
  ctp_pkg::ctp_result_t res_w;
  logic                 q_full_w, q_valid_w, q_pop_w;

  // Classifier
  ctp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .char_byte_i (char_byte_i),
    .cls_o       (cls_w)
  );

  // Queue between classifier and parser
  ctp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (cls_w),
    .full_o  (q_full_w),
    .pop_i   (q_pop_w),
    .valid_o (q_valid_w),
    .data_o  (q_data_w)
  );

  // Parser and result register
  ctp_back #(
    .MAX_TAGS      (MAX_TAGS),
    .MAX_PARAMS    (MAX_PARAMS),
    .MAX_PARAM_LEN (MAX_PARAM_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid_w),
    .q_data_i    (q_data_w),
    .q_pop_o     (q_pop_w),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_w)
  );

  assign in_stall_o      = q_full_w;
  assign byte_value_o    = res_w.byte_value;
  assign role_o          = res_w.role;
  assign segment_index_o = res_w.segment_index;
  assign tag_type_o      = res_w.tag_type;
  assign param_index_o   = res_w.param_index;
  assign rollback_o      = res_w.rollback;
  assign parse_ok_o      = res_w.parse_ok;

endmodule

`default_nettype wire

### dv/tb_chat_markup_tag_parser.sv
// Testbench for chat_markup_tag_parser: directed and random message bytes, with
// every result checked against an in-bench parser model. Depends on ctp_pkg.
`timescale 1ns / 1ps

module tb_chat_markup_tag_parser;
  import ctp_pkg::*;

  localparam int unsigned MAX_TAGS       = 16;
  localparam int unsigned MAX_PARAMS     = 4;
  localparam int unsigned MAX_PARAM_LEN  = 32;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES    = 475;
  localparam logic [7:0]  END_BYTE       = 8'h00;

  // DUT inputs, all known from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  char_byte_i = '0;
  logic        out_stall_i = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] byte_value_o;
  logic [3:0] role_o;
  logic [4:0] segment_index_o;
  logic [7:0] tag_type_o;
  logic [2:0] param_index_o;
  logic       rollback_o;
  logic       parse_ok_o;

  chat_markup_tag_parser #(
    .MAX_TAGS      (MAX_TAGS),
    .MAX_PARAMS    (MAX_PARAMS),
    .MAX_PARAM_LEN (MAX_PARAM_LEN)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_byte_i     (char_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_value_o    (byte_value_o),
    .role_o          (role_o),
    .segment_index_o (segment_index_o),
    .tag_type_o      (tag_type_o),
    .param_index_o   (param_index_o),
    .rollback_o      (rollback_o),
    .parse_ok_o      (parse_ok_o)
  );

  always #2 clk_i = ~clk_i;

  // Model copy of the registers
  logic [7:0]  left_sep  = LEFT_SEP_RST;
  logic [7:0]  right_sep = RIGHT_SEP_RST;
  logic [7:0]  psep      = PARAM_SEP_RST;
  logic [7:0]  csep      = CONTENT_SEP_RST;
  logic [63:0] tag_words [4] = '{default: '0};

  // Model parse state
  ctp_phase_e  parse_phase = PH_IDLE;
  int unsigned seg_count   = 0;
  logic [7:0]  cur_type    = '0;
  int unsigned param_count = 0;
  int unsigned param_len   = 0;
  logic        limit_hit   = 1'b0;

  ctp_result_t predicted_bytes [$];
  logic [7:0]  msg_bytes [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_off_req = 1'b0;
  bit          no_idle      = 1'b0;

  function automatic void clear_parse_state();
    parse_phase = PH_IDLE;
    seg_count   = 0;
    cur_type    = '0;
    param_count = 0;
    param_len   = 0;
    limit_hit   = 1'b0;
  endfunction

  // Expected result of one message byte; advances the model state
  function automatic ctp_result_t parse_next_byte(input logic [7:0] b);
    ctp_result_t r;
    logic        tag_fail;
    r = '0;
    tag_fail = 1'b0;
    r.byte_value = b;
    if (b == END_BYTE) begin
      r.rollback = (parse_phase == PH_TYPE) || (parse_phase == PH_PARAMS) ||
                   (parse_phase == PH_CONTENT);
      r.parse_ok = !limit_hit && (seg_count < MAX_TAGS);
      r.role = ROLE_END;
      r.segment_index = 5'(seg_count);
      clear_parse_state();
    end else if (parse_phase == PH_IDLE || (parse_phase == PH_TEXT && b == left_sep)) begin
      // a new segment starts here, unless the segment budget is spent
      if (seg_count >= MAX_TAGS) begin
        limit_hit = 1'b1;
        parse_phase = PH_IGNORE;
        r.role = ROLE_IGNORED;
        r.segment_index = 5'(seg_count);
      end else begin
        r.segment_index = 5'(seg_count);
        seg_count++;
        if (b == left_sep) begin
          r.role = ROLE_OPEN;
          parse_phase = PH_TYPE;
        end else begin
          r.role = ROLE_TEXT;
          parse_phase = PH_TEXT;
        end
      end
    end else begin
      r.segment_index = 5'(seg_count - 1);
      case (parse_phase)
        PH_TEXT: r.role = ROLE_TEXT;
        PH_TYPE: begin
          if (tag_words[b[7:6]][b[5:0]]) begin
            r.role = ROLE_TYPE;
            r.tag_type = b;
            cur_type = b;
            param_count = 0;
            param_len = 0;
            parse_phase = PH_PARAMS;
          end else begin
            tag_fail = 1'b1;
          end
        end
        PH_PARAMS: begin
          // separator checks in priority order: param, content, right
          r.tag_type = cur_type;
          if (b == psep) begin
            r.role = ROLE_PSEP;
            param_len = 0;
          end else if (b == csep) begin
            r.role = ROLE_CSEP;
            parse_phase = PH_CONTENT;
          end else if (b == right_sep) begin
            r.role = ROLE_CLOSE;
            parse_phase = PH_IDLE;
          end else if (param_len > 0) begin
            if (param_len >= MAX_PARAM_LEN - 1) begin
              tag_fail = 1'b1;
            end else begin
              param_len++;
              r.role = ROLE_PARAM;
              r.param_index = 3'(param_count - 1);
            end
          end else if (param_count >= MAX_PARAMS) begin
            tag_fail = 1'b1;
          end else begin
            param_count++;
            param_len = 1;
            r.role = ROLE_PARAM;
            r.param_index = 3'(param_count - 1);
          end
        end
        PH_CONTENT: begin
          r.tag_type = cur_type;
          if (b == right_sep) begin
            r.role = ROLE_CLOSE;
            parse_phase = PH_IDLE;
          end else begin
            r.role = ROLE_CONTENT;
          end
        end
        PH_FALLBACK: r.role = ROLE_FALLBACK;
        default: begin
          r.role = ROLE_IGNORED;
          r.segment_index = 5'(seg_count);
        end
      endcase
      // failed tag: rest of the message is raw fallback
      if (tag_fail) begin
        r.role = ROLE_FALLBACK;
        r.rollback = 1'b1;
        r.tag_type = '0;
        r.param_index = '0;
        cur_type = '0;
        param_count = 0;
        param_len = 0;
        parse_phase = PH_FALLBACK;
      end
    end
    return r;
  endfunction

  // Nonzero random byte different from the three given values
  function automatic logic [7:0] pick_plain(input logic [7:0] a, input logic [7:0] c,
                                            input logic [7:0] d);
    logic [7:0] v;
    int         n;
    v = 8'($urandom_range(255, 1));
    for (n = 0; n < 64 && (v == a || v == c || v == d); n++) v = 8'($urandom_range(255, 1));
    return v;
  endfunction

  // Tag type code, valid under the current mask most of the time
  function automatic logic [7:0] pick_type();
    logic [7:0] t;
    int         n;
    t = 8'($urandom_range(255, 1));
    if ($urandom_range(9) != 0) begin
      for (n = 0; n < 64 && !tag_words[t[7:6]][t[5:0]]; n++) t = 8'($urandom_range(255, 1));
    end
    return t;
  endfunction

  // Mostly well-formed message: text runs and tags with random content
  function automatic void compose_message();
    int unsigned n_seg, s, p, n_par, len, k, ending;
    msg_bytes.delete();
    n_seg = ($urandom_range(4) == 0) ? $urandom_range(20, 13) : $urandom_range(5, 1);
    for (s = 0; s < n_seg; s++) begin
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(5, 1);
        repeat (len) msg_bytes.push_back(pick_plain(left_sep, left_sep, left_sep));
      end else begin
        msg_bytes.push_back(left_sep);
        msg_bytes.push_back(pick_type());
        n_par = $urandom_range(MAX_PARAMS + 1);
        for (p = 0; p < n_par; p++) begin
          k = $urandom_range(2, (p == 0) ? 0 : 1);
          repeat (k) msg_bytes.push_back(psep);
          len = ($urandom_range(11) == 0) ? $urandom_range(MAX_PARAM_LEN, MAX_PARAM_LEN - 2)
                                          : $urandom_range(4, 1);
          repeat (len) msg_bytes.push_back(pick_plain(psep, csep, right_sep));
        end
        // occasional stray byte inside the tag
        if ($urandom_range(19) == 0) msg_bytes.push_back(8'($urandom_range(255, 1)));
        ending = $urandom_range(9);
        if (ending == 0) return;  // message cut off inside the tag
        if (ending < 5) begin
          msg_bytes.push_back(csep);
          len = $urandom_range(5);
          repeat (len) msg_bytes.push_back(pick_plain(right_sep, right_sep, right_sep));
        end
        msg_bytes.push_back(right_sep);
      end
    end
  endfunction

  // One byte request; holds until accepted, then records its expected result
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (!no_idle && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted_bytes.push_back(parse_next_byte(b));
  endtask

  task automatic send_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(END_BYTE);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i]);
    send_byte(END_BYTE);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (predicted_bytes.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic put_reg(input ctp_cfg_idx_e idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Write all registers; separators carry junk in the unused upper bits
  task automatic load_config(input logic [7:0] l, input logic [7:0] r, input logic [7:0] p,
                             input logic [7:0] c, input logic [63:0] w0,
                             input logic [63:0] w1, input logic [63:0] w2,
                             input logic [63:0] w3);
    put_reg(CFG_LEFT_SEP,    {$urandom, 24'($urandom), l});
    put_reg(CFG_RIGHT_SEP,   {$urandom, 24'($urandom), r});
    put_reg(CFG_PARAM_SEP,   {$urandom, 24'($urandom), p});
    put_reg(CFG_CONTENT_SEP, {$urandom, 24'($urandom), c});
    put_reg(CFG_TAGS_W0, w0);
    put_reg(CFG_TAGS_W1, w1);
    put_reg(CFG_TAGS_W2, w2);
    put_reg(CFG_TAGS_W3, w3);
    cfg_we_i <= 1'b0;
    left_sep = l;
    right_sep = r;
    psep = p;
    csep = c;
    tag_words = '{w0, w1, w2, w3};
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      compose_message();
      sent += msg_bytes.size() + 1;
      send_message();
    end
    drain_results();
  endtask

  // Reset registers: no valid tag types, so any tag falls back
  task automatic test_reset_registers();
    send_string("x[bc");
    drain_results();
  endtask

  // Valid types: code 0, 'b' and 0xFF; default separators
  task automatic test_tag_forms();
    load_config(LEFT_SEP_RST, RIGHT_SEP_RST, PARAM_SEP_RST, CONTENT_SEP_RST,
                64'h1, 64'h0000_0004_0000_0000, 64'h0, 64'h8000_0000_0000_0000);
    send_string("[bk  v:z]");
    send_byte(8'hFF);
    send_byte(LEFT_SEP_RST);
    send_byte(8'hFF);
    send_byte(RIGHT_SEP_RST);
    send_byte(END_BYTE);
    drain_results();
  endtask

  // One parameter too many, and a terminator right after the open byte
  task automatic test_tag_failures();
    send_string("[b1 2 3 4 5");
    send_string("[");
    drain_results();
  endtask

  // Content separator equal to right separator; then all separators zero
  task automatic test_separator_collisions();
    load_config(8'hFF, 8'h01, 8'h02, 8'h01, '1, '1, '1, '1);
    send_byte(8'hFF);
    send_byte("b");
    send_byte(8'h01);
    send_byte("a");
    send_byte(8'h01);
    send_byte(END_BYTE);
    drain_results();
    load_config(8'h00, 8'h00, 8'h00, 8'h00, '1, '1, '1, '1);
    send_string("a");
    send_byte(END_BYTE);
    drain_results();
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    load_config(LEFT_SEP_RST, RIGHT_SEP_RST, PARAM_SEP_RST, CONTENT_SEP_RST,
                '1, '1, '1, '1);
    hold_off_req = 1'b1;
    run_random(60);
  endtask

  task automatic test_random_traffic();
    logic [7:0] l, r, p, c;
    // default separators, half-populated mask
    load_config(LEFT_SEP_RST, RIGHT_SEP_RST, PARAM_SEP_RST, CONTENT_SEP_RST,
                {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    run_random(PHASE_BYTES);
    // distinct random separators, sparse mask, no idling on either side
    l = 8'($urandom_range(255, 1));
    r = pick_plain(l, l, l);
    p = pick_plain(l, r, r);
    c = pick_plain(l, r, p);
    load_config(l, r, p, c, {$urandom, $urandom} & {$urandom, $urandom},
                {$urandom, $urandom} & {$urandom, $urandom},
                {$urandom, $urandom} & {$urandom, $urandom},
                {$urandom, $urandom} & {$urandom, $urandom});
    no_idle = 1'b1;
    run_random(PHASE_BYTES);
    no_idle = 1'b0;
    // colliding separators, dense mask
    l = 8'($urandom_range(255, 1));
    r = 8'($urandom);
    p = $urandom_range(1) ? r : 8'($urandom);
    c = $urandom_range(1) ? p : 8'($urandom);
    load_config(l, r, p, c, {$urandom, $urandom} | {$urandom, $urandom},
                {$urandom, $urandom} | {$urandom, $urandom},
                {$urandom, $urandom} | {$urandom, $urandom},
                {$urandom, $urandom} | {$urandom, $urandom});
    run_random(PHASE_BYTES);
    // extreme separator values, every type valid
    load_config(8'h01, 8'hFF, 8'hFE, 8'h80, '1, '1, '1, '1);
    run_random(PHASE_BYTES);
  endtask

  // Result side: random stalls, or a long hold-off on request
  initial begin : result_throttle
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < 6);
      end
    end
  end

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    ctp_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (predicted_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual byte %0d",
                 $time, byte_value_o);
      end else begin
        want = predicted_bytes.pop_front();
        check_field("byte_value", want.byte_value, byte_value_o);
        check_field("role", 8'(want.role), 8'(role_o));
        check_field("segment_index", 8'(want.segment_index), 8'(segment_index_o));
        check_field("tag_type", want.tag_type, tag_type_o);
        check_field("param_index", 8'(want.param_index), 8'(param_index_o));
        check_field("rollback", 8'(want.rollback), 8'(rollback_o));
        check_field("parse_ok", 8'(want.parse_ok), 8'(parse_ok_o));
      end
    end
  end

  // Watchdog: cycles in a row with no request accepted on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb_chat_markup_tag_parser: errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_registers();
    test_tag_forms();
    test_tag_failures();
    test_separator_collisions();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_chat_markup_tag_parser: clean");
    else
      $display("tb_chat_markup_tag_parser: errors");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ctp_pkg.sv
rtl/core/ctp_front.sv
rtl/core/ctp_queue.sv
rtl/core/ctp_back.sv
rtl/core/chat_markup_tag_parser.sv
dv/tb_chat_markup_tag_parser.sv
